// ===== src/fram_pkg.sv =====
// shared types, constants and codes for the four register alu machine
package fram_pkg;

  localparam int DefDataWidth = 64;
  localparam int DefNumRegs   = 4;
  localparam int FieldWidth   = 64;

  // operation codes
  localparam logic [2:0] FUNC_LOAD = 3'd0;
  localparam logic [2:0] FUNC_ADD  = 3'd1;
  localparam logic [2:0] FUNC_MUL  = 3'd2;
  localparam logic [2:0] FUNC_DIV  = 3'd3;
  localparam logic [2:0] FUNC_MOD  = 3'd4;
  localparam logic [2:0] FUNC_EQL  = 3'd5;
  // unused codes, executed as no operation
  localparam logic [2:0] FUNC_RSV6 = 3'd6;
  localparam logic [2:0] FUNC_RSV7 = 3'd7;

  typedef struct packed {
    logic [2:0]             func;
    logic [1:0]             dest_reg;
    logic                   use_immediate;
    logic [1:0]             src_reg;
    logic [FieldWidth-1:0]  immediate_value;
    logic [FieldWidth-1:0]  input_value;
    logic                   first_of_program;
  } fram_in_t;

  typedef struct packed {
    logic [FieldWidth-1:0] reg_w;
    logic [FieldWidth-1:0] reg_x;
    logic [FieldWidth-1:0] reg_y;
    logic [FieldWidth-1:0] reg_z;
    logic                  fault;
  } fram_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OPER,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } fram_state_t;

  // controller to datapath
  typedef struct packed {
    logic load_item;   // capture word, apply program start
    logic fetch;       // read operands, start unit
    logic mul_step;    // one multiplier partial product
    logic div_step;    // one divider bit
    logic write_back;  // write destination, fill result
  } fram_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_mul;
    logic is_div;
    logic mul_last;
    logic div_last;
  } fram_stat_t;

endpackage

// ===== src/fram_ctrl.sv =====
// controller state machine for the four register alu machine
module fram_ctrl
  import fram_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  fram_stat_t stat,
  output fram_cmd_t  cmd
);

  fram_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_OPER;
        end
      end
      ST_OPER: begin
        cmd.fetch = 1'b1;
        if (stat.is_mul) begin
          state_next = ST_MUL;
        end else if (stat.is_div) begin
          state_next = ST_DIV;
        end else begin
          cmd.write_back = 1'b1;
          state_next     = ST_DONE;
        end
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        if (stat.mul_last) begin
          cmd.write_back = 1'b1;
          state_next     = ST_DONE;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          cmd.write_back = 1'b1;
          state_next     = ST_DONE;
        end
      end
      ST_DONE: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== src/fram_dpath.sv =====
// datapath: register file, multiplier and divider of the alu machine
module fram_dpath
  import fram_pkg::*;
#(
  parameter int DATA_WIDTH = DefDataWidth,
  parameter int NUM_REGS   = DefNumRegs
) (
  input  logic                  clk,
  input  logic                  rst,
  input  fram_in_t              in_word,
  input  logic [FieldWidth-1:0] initial_z,
  input  fram_cmd_t             cmd,
  output fram_stat_t            stat,
  output fram_out_t             out_word
);

  localparam int DW   = DATA_WIDTH;
  localparam int RW   = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int HW   = (DW + 1) / 2;
  localparam int CW   = $clog2(DW + 1);
  localparam int NOUT = 4;
  localparam logic [1:0] MulLast = 2'd2;

  logic [DW-1:0] regs [NUM_REGS];
  fram_in_t      item;
  logic [RW-1:0] d_idx;
  logic [DW-1:0] opa, opb;
  logic [DW-1:0] result;
  logic          fault;

  // multiplier state: three half-width partial products
  logic [DW-1:0] mul_acc;
  logic [1:0]    mul_phase;

  // divider state
  logic [DW-1:0] quo, rem, dvs;
  logic [CW-1:0] div_cnt;
  logic          neg_q, neg_r;

  // register index wrap, index is below four so one subtract is enough
  function automatic logic [RW-1:0] wrap_idx(input logic [1:0] r);
    return (32'(r) >= NUM_REGS) ? RW'(32'(r) - NUM_REGS) : RW'(r);
  endfunction

  logic [RW-1:0] s_idx;
  logic [DW-1:0] b_sel;
  assign s_idx = wrap_idx(item.src_reg);
  assign b_sel = item.use_immediate ? item.immediate_value[DW-1:0] : regs[s_idx];

  assign stat.is_mul   = (item.func == FUNC_MUL);
  assign stat.is_div   = (item.func == FUNC_DIV || item.func == FUNC_MOD) &&
                         (b_sel != '0) &&
                         !(regs[wrap_idx(item.dest_reg)] == {1'b1, {(DW-1){1'b0}}} &&
                           b_sel == '1);
  assign stat.mul_last = (mul_phase == MulLast);
  assign stat.div_last = (div_cnt == CW'(1));

  // divider one bit step
  logic [DW:0]   rem_sh, rem_sub;
  assign rem_sh  = {rem, quo[DW-1]};
  assign rem_sub = rem_sh - {1'b0, dvs};

  // half products: lo*lo, then hi*lo and lo*hi shifted up, hi*hi drops out
  logic [DW-1:0]   pp;
  logic [HW-1:0]   mul_x, mul_y;
  logic [2*HW-1:0] mul_prod;
  always_comb begin
    case (mul_phase)
      2'd0: begin
        mul_x = opa[HW-1:0];
        mul_y = opb[HW-1:0];
      end
      2'd1: begin
        mul_x = HW'(opa[DW-1:HW]);
        mul_y = opb[HW-1:0];
      end
      default: begin
        mul_x = opa[HW-1:0];
        mul_y = HW'(opb[DW-1:HW]);
      end
    endcase
    mul_prod = mul_x * mul_y;
    pp = (mul_phase == 2'd0) ? DW'(mul_prod) : DW'(mul_prod) << HW;
  end

  // next destination value
  always_comb begin
    result = opa;
    case (item.func)
      FUNC_LOAD: result = item.input_value[DW-1:0];
      FUNC_ADD:  result = opa + opb;
      FUNC_MUL:  result = mul_acc + pp;
      FUNC_DIV:  result = neg_q ? DW'(0) - {quo[DW-2:0], ~rem_sub[DW]} :
                                  {quo[DW-2:0], ~rem_sub[DW]};
      FUNC_MOD:  result = neg_r ? DW'(0) - (rem_sub[DW] ? rem_sh[DW-1:0] : rem_sub[DW-1:0])
                                : (rem_sub[DW] ? rem_sh[DW-1:0] : rem_sub[DW-1:0]);
      FUNC_EQL:  result = DW'(opa == opb);
      default:   result = opa;
    endcase
  end

  // item capture, register file and units
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) regs[i] <= '0;
      fault     <= 1'b0;
      mul_phase <= '0;
      div_cnt   <= '0;
    end else begin
      if (cmd.load_item) begin
        item <= in_word;
        if (in_word.first_of_program) begin
          for (int i = 0; i < NUM_REGS; i++) regs[i] <= '0;
          if (NUM_REGS > 3) regs[3 % NUM_REGS] <= initial_z[DW-1:0];
        end
      end
      if (cmd.fetch) begin
        d_idx     <= wrap_idx(item.dest_reg);
        opa       <= regs[wrap_idx(item.dest_reg)];
        opb       <= b_sel;
        fault     <= (item.func == FUNC_DIV || item.func == FUNC_MOD) && !stat.is_div;
        mul_acc   <= '0;
        mul_phase <= '0;
        neg_q     <= regs[wrap_idx(item.dest_reg)][DW-1] ^ b_sel[DW-1];
        neg_r     <= regs[wrap_idx(item.dest_reg)][DW-1];
        quo       <= regs[wrap_idx(item.dest_reg)][DW-1] ?
                     DW'(0) - regs[wrap_idx(item.dest_reg)] : regs[wrap_idx(item.dest_reg)];
        dvs       <= b_sel[DW-1] ? DW'(0) - b_sel : b_sel;
        rem       <= '0;
        div_cnt   <= CW'(DW);
      end
      if (cmd.mul_step && !cmd.write_back) begin
        mul_acc   <= mul_acc + pp;
        mul_phase <= mul_phase + 2'd1;
      end
      if (cmd.div_step && !cmd.write_back) begin
        rem     <= rem_sub[DW] ? rem_sh[DW-1:0] : rem_sub[DW-1:0];
        quo     <= {quo[DW-2:0], ~rem_sub[DW]};
        div_cnt <= div_cnt - CW'(1);
      end
      if (cmd.write_back) begin
        if (cmd.fetch) begin
          regs[wrap_idx(item.dest_reg)] <= (item.func == FUNC_LOAD) ?
              item.input_value[DW-1:0] :
              (item.func == FUNC_ADD) ? regs[wrap_idx(item.dest_reg)] + b_sel :
              (item.func == FUNC_EQL) ? DW'(regs[wrap_idx(item.dest_reg)] == b_sel) :
              regs[wrap_idx(item.dest_reg)];
        end else begin
          regs[d_idx] <= result;
        end
      end
    end
  end

  // result word, registers sign extended
  logic [DW-1:0] outv [NOUT];
  always_comb begin
    for (int i = 0; i < NOUT; i++) begin
      outv[i] = (i < NUM_REGS) ? regs[RW'(i % NUM_REGS)] : '0;
    end
  end
  assign out_word.reg_w = FieldWidth'(signed'(outv[0]));
  assign out_word.reg_x = FieldWidth'(signed'(outv[1]));
  assign out_word.reg_y = FieldWidth'(signed'(outv[2]));
  assign out_word.reg_z = FieldWidth'(signed'(outv[3]));
  assign out_word.fault = fault;

endmodule

// ===== src/four_register_alu_machine.sv =====
// four register alu machine: runs one instruction per input word
//
// in_valid/in_ready take one instruction word (fram_in_t); out_valid/out_ready
// return one result word (fram_out_t) holding w, x, y, z and the fault flag.
// cfg_we with cfg_data writes initial_z, loaded into z when a word marks the
// start of a program. Write it only while the block is idle.
// One word at a time: a word is accepted in the idle state, its operands are
// fetched in the operate state, and load, add, equal and unused codes write
// back there; multiply forms three half-width partial products through one
// half-width multiplier, and divide and remainder use a restoring divider
// that resolves one quotient bit per cycle. The next word is taken in the
// cycle after the hand-off. Refused divides (by zero, most negative by minus
// one) skip the divider, keep the destination, set fault and write back in
// the operate state.
// Reset clears all registers, initial_z and the controller.
// While the receiver stalls the result holds and no new word is taken.
module four_register_alu_machine
  import fram_pkg::*;
#(
  parameter int DATA_WIDTH = DefDataWidth,
  parameter int NUM_REGS   = DefNumRegs
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  fram_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output fram_out_t             out_data,
  input  logic                  cfg_we,
  input  logic [FieldWidth-1:0] cfg_data
);

  logic [FieldWidth-1:0] initial_z;
  fram_cmd_t  cmd;
  fram_stat_t stat;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      initial_z <= '0;
    end else if (cfg_we) begin
      initial_z <= cfg_data;
    end
  end

  // controller
  fram_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .stat, .cmd
  );

  // datapath
  fram_dpath #(.DATA_WIDTH(DATA_WIDTH), .NUM_REGS(NUM_REGS)) u_dpath (
    .clk, .rst, .in_word(in_data), .initial_z, .cmd, .stat, .out_word(out_data)
  );

  // a result follows an accepted word before the next is taken
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result pending");

  // acceptance starts work, no result in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (!in_ready && !out_valid))
    else $error("accepted word did not start work");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result changed under stall");

endmodule
